// ===== src/tsub_pkg.sv =====
// ----------------------------------------------------------------------------
// tsub_pkg: shared types and constants of the triangle subdivider
// vertex types, split mode codes and the divide-by-three reciprocal
// ----------------------------------------------------------------------------
package tsub_pkg;

    typedef logic [31:0] coord_t;
    typedef logic [2:0][31:0] vec_t;   // [0] x, [1] y, [2] z

    // split mode codes; the unused code behaves as the six-way split
    localparam logic [1:0] MODE_BISECT  = 2'd0;
    localparam logic [1:0] MODE_TRISECT = 2'd1;
    localparam logic [1:0] MODE_SIXWAY  = 2'd2;

    // floor(x/3) = (x * RECIP3) >> RECIP_SHIFT, exact for x < 2**19
    localparam int          RECIP_SHIFT = 20;
    localparam logic [18:0] RECIP3      = 19'd349526;

    // offset that makes a three-term sum non-negative: 3 * 2**31
    localparam logic [33:0] SUM_OFFSET = 34'h1_8000_0000;

    // enables of the divider stages
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } tsub_adv_t;

    function automatic logic [2:0] last_index(input logic [1:0] mode);
        logic [2:0] idx;
        unique case (mode)
            MODE_BISECT:  idx = 3'd1;
            MODE_TRISECT: idx = 3'd2;
            default:      idx = 3'd5;
        endcase
        return idx;
    endfunction

endpackage

// ===== src/tsub_div3.sv =====
// ----------------------------------------------------------------------------
// tsub_div3: three-stage floor division by three
// takes a biased non-negative 34-bit sum and returns floor(sum/3) - 2**31
// ----------------------------------------------------------------------------
module tsub_div3 (
    input  logic                clk,
    input  tsub_pkg::tsub_adv_t adv,
    input  logic [33:0]         sum_in,
    output tsub_pkg::coord_t    quot
);

    logic [16:0] hi_reg;
    logic [14:0] qhi_reg;
    logic [16:0] lo_reg;
    logic [14:0] qhi4_reg;
    logic [18:0] t_reg;
    logic [31:0] quot_reg;

    logic [35:0] prod_hi;
    logic [16:0] rem_hi;
    logic [37:0] prod_lo;

    // upper digit: 17 bits times the reciprocal
    assign prod_hi = {19'd0, sum_in[33:17]} * {17'd0, tsub_pkg::RECIP3};

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            hi_reg  <= sum_in[33:17];
            qhi_reg <= prod_hi[34:20];
            lo_reg  <= sum_in[16:0];
        end
    end

    // remainder of the upper digit joins the lower digit
    assign rem_hi = hi_reg - ({1'b0, qhi_reg, 1'b0} + {2'b00, qhi_reg});

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            qhi4_reg <= qhi_reg;
            t_reg    <= {rem_hi[1:0], lo_reg};
        end
    end

    assign prod_lo = {19'd0, t_reg} * {19'd0, tsub_pkg::RECIP3};

    // removing the bias of 2**31 flips the top bit
    always_ff @(posedge clk)
    begin
        if (adv.s5)
            quot_reg <= {qhi4_reg, prod_lo[36:20]} ^ 32'h8000_0000;
    end

    assign quot = quot_reg;

endmodule

// ===== src/triangle_subdivider.sv =====
// ----------------------------------------------------------------------------
// triangle_subdivider: splits a triangle into two, three or six pieces
// five-stage datapath for edge midpoints and centroid, then a piece sequencer
// ----------------------------------------------------------------------------
// A triangle is taken when start is high and busy is low. Its pieces
// appear one per cycle on the piece ports, each marked by piece_valid
// for exactly one cycle, numbered from 0, with last_piece on the final
// one: two pieces in bisect mode, three in trisect mode, six in the
// six-way mode (and for the unused mode code). The receiver cannot hold
// pieces off. The piece sequencer issues one piece per cycle, so the block
// sustains one triangle per two, three or six pieces by mode; the next
// triangle's first piece follows the previous last piece with no gap. Up to five
// triangles sit in the datapath while the sequencer is busy; busy rises when
// the first stage cannot move on. split_mode is sampled when a triangle is
// taken and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module triangle_subdivider (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        split_mode_we,
    input  logic [1:0]  split_mode_data,
    // triangle in
    input  logic        start,
    output logic        busy,
    input  logic [31:0] a_x,
    input  logic [31:0] a_y,
    input  logic [31:0] a_z,
    input  logic [31:0] b_x,
    input  logic [31:0] b_y,
    input  logic [31:0] b_z,
    input  logic [31:0] c_x,
    input  logic [31:0] c_y,
    input  logic [31:0] c_z,
    // pieces out
    output logic        piece_valid,
    output logic [31:0] v0_x,
    output logic [31:0] v0_y,
    output logic [31:0] v0_z,
    output logic [31:0] v1_x,
    output logic [31:0] v1_y,
    output logic [31:0] v1_z,
    output logic [31:0] v2_x,
    output logic [31:0] v2_y,
    output logic [31:0] v2_z,
    output logic [2:0]  piece_number,
    output logic        last_piece
);

    logic [1:0] split_mode_reg;

    // stage 1: captured vertices
    logic                s1_valid_reg;
    logic [1:0]          s1_mode_reg;
    tsub_pkg::vec_t      s1_a_reg, s1_b_reg, s1_c_reg;

    // stage 2: midpoints and biased sums
    logic                s2_valid_reg;
    logic [1:0]          s2_mode_reg;
    tsub_pkg::vec_t      s2_a_reg, s2_b_reg, s2_c_reg;
    tsub_pkg::vec_t      s2_ab_reg, s2_ac_reg, s2_cb_reg;
    logic [2:0][33:0]    s2_sum_reg;

    // stages 3 to 5: vertices and midpoints ride along with the divider
    logic                s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic [1:0]          s3_mode_reg, s4_mode_reg, s5_mode_reg;
    tsub_pkg::vec_t      s3_a_reg, s3_b_reg, s3_c_reg;
    tsub_pkg::vec_t      s3_ab_reg, s3_ac_reg, s3_cb_reg;
    tsub_pkg::vec_t      s4_a_reg, s4_b_reg, s4_c_reg;
    tsub_pkg::vec_t      s4_ab_reg, s4_ac_reg, s4_cb_reg;
    tsub_pkg::vec_t      s5_a_reg, s5_b_reg, s5_c_reg;
    tsub_pkg::vec_t      s5_ab_reg, s5_ac_reg, s5_cb_reg;
    tsub_pkg::vec_t      s5_o;

    // piece sequencer
    logic                emit_valid_reg;
    logic [2:0]          piece_reg;
    logic [2:0]          piece_next;
    logic [1:0]          emit_mode_reg;
    tsub_pkg::vec_t      e_a_reg, e_b_reg, e_c_reg;
    tsub_pkg::vec_t      e_ab_reg, e_ac_reg, e_cb_reg, e_o_reg;

    // flow control
    logic                emit_last, emit_free;
    logic                s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;
    logic                accept;
    tsub_pkg::tsub_adv_t adv;

    tsub_pkg::vec_t      ab_c, ac_c, cb_c;
    logic [2:0][33:0]    sum_c;
    tsub_pkg::vec_t      v0, v1, v2;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            split_mode_reg <= tsub_pkg::MODE_SIXWAY;
        else if (split_mode_we)
            split_mode_reg <= split_mode_data;
    end

    // ------------------------------------------------------------------
    // flow control: a stage moves on when the one after it is free
    // ------------------------------------------------------------------
    assign emit_last = emit_valid_reg && (piece_reg == tsub_pkg::last_index(emit_mode_reg));
    assign emit_free = !emit_valid_reg || emit_last;
    assign s5_ready  = !s5_valid_reg || emit_free;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign busy      = !s1_ready;
    assign accept    = start && s1_ready;

    assign adv.s3 = s3_ready;
    assign adv.s4 = s4_ready;
    assign adv.s5 = s5_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            emit_valid_reg <= 1'b0;
            piece_reg      <= 3'd0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= start;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
            if (s5_ready)
                s5_valid_reg <= s4_valid_reg;
            if (emit_free)
                emit_valid_reg <= s5_valid_reg;
            piece_reg <= piece_next;
        end
    end

    // a new triangle starts at piece zero, otherwise step to the next piece
    assign piece_next = emit_free ? 3'd0 : piece_reg + 3'd1;

    // ------------------------------------------------------------------
    // stage 1: capture the beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= split_mode_reg;
            s1_a_reg    <= {a_z, a_y, a_x};
            s1_b_reg    <= {b_z, b_y, b_x};
            s1_c_reg    <= {c_z, c_y, c_x};
        end
    end

    // ------------------------------------------------------------------
    // stage 2: edge midpoints (floor of half the 33-bit sum) and the
    // centroid sum biased by 3 * 2**31 so it is never negative
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [32:0] s_ab, s_ac, s_cb;
            s_ab = {s1_a_reg[i][31], s1_a_reg[i]} + {s1_b_reg[i][31], s1_b_reg[i]};
            s_ac = {s1_a_reg[i][31], s1_a_reg[i]} + {s1_c_reg[i][31], s1_c_reg[i]};
            s_cb = {s1_c_reg[i][31], s1_c_reg[i]} + {s1_b_reg[i][31], s1_b_reg[i]};
            ab_c[i]  = s_ab[32:1];
            ac_c[i]  = s_ac[32:1];
            cb_c[i]  = s_cb[32:1];
            sum_c[i] = {{2{s1_a_reg[i][31]}}, s1_a_reg[i]}
                     + {{2{s1_b_reg[i][31]}}, s1_b_reg[i]}
                     + {{2{s1_c_reg[i][31]}}, s1_c_reg[i]}
                     + tsub_pkg::SUM_OFFSET;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_c_reg    <= s1_c_reg;
            s2_ab_reg   <= ab_c;
            s2_ac_reg   <= ac_c;
            s2_cb_reg   <= cb_c;
            s2_sum_reg  <= sum_c;
        end
    end

    // ------------------------------------------------------------------
    // stages 3 to 5: centroid, one divider per axis
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        tsub_div3 u_div3 (
            .clk    (clk),
            .adv    (adv),
            .sum_in (s2_sum_reg[g]),
            .quot   (s5_o[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_mode_reg <= s2_mode_reg;
            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_c_reg    <= s2_c_reg;
            s3_ab_reg   <= s2_ab_reg;
            s3_ac_reg   <= s2_ac_reg;
            s3_cb_reg   <= s2_cb_reg;
        end
        if (s4_ready)
        begin
            s4_mode_reg <= s3_mode_reg;
            s4_a_reg    <= s3_a_reg;
            s4_b_reg    <= s3_b_reg;
            s4_c_reg    <= s3_c_reg;
            s4_ab_reg   <= s3_ab_reg;
            s4_ac_reg   <= s3_ac_reg;
            s4_cb_reg   <= s3_cb_reg;
        end
        if (s5_ready)
        begin
            s5_mode_reg <= s4_mode_reg;
            s5_a_reg    <= s4_a_reg;
            s5_b_reg    <= s4_b_reg;
            s5_c_reg    <= s4_c_reg;
            s5_ab_reg   <= s4_ab_reg;
            s5_ac_reg   <= s4_ac_reg;
            s5_cb_reg   <= s4_cb_reg;
        end
    end

    // ------------------------------------------------------------------
    // piece sequencer: holds one triangle's points while its pieces go out
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (emit_free)
        begin
            emit_mode_reg <= s5_mode_reg;
            e_a_reg       <= s5_a_reg;
            e_b_reg       <= s5_b_reg;
            e_c_reg       <= s5_c_reg;
            e_ab_reg      <= s5_ab_reg;
            e_ac_reg      <= s5_ac_reg;
            e_cb_reg      <= s5_cb_reg;
            e_o_reg       <= s5_o;
        end
    end

    // corner selection per mode and piece; in bisect mode the midpoint of
    // B and C is the same as the CB midpoint
    always_comb
    begin
        v0 = e_o_reg;
        v1 = e_a_reg;
        v2 = e_ab_reg;
        unique case (emit_mode_reg)
            tsub_pkg::MODE_BISECT:
            begin
                v0 = e_a_reg;
                v2 = e_cb_reg;
                v1 = (piece_reg == 3'd0) ? e_b_reg : e_c_reg;
            end
            tsub_pkg::MODE_TRISECT:
            begin
                unique case (piece_reg)
                    3'd0:    begin v0 = e_c_reg; v1 = e_a_reg; v2 = e_o_reg; end
                    3'd1:    begin v0 = e_c_reg; v1 = e_o_reg; v2 = e_b_reg; end
                    default: begin v0 = e_o_reg; v1 = e_a_reg; v2 = e_b_reg; end
                endcase
            end
            default:
            begin
                unique case (piece_reg)
                    3'd0:    begin v0 = e_ac_reg; v1 = e_a_reg;  v2 = e_o_reg;  end
                    3'd1:    begin v0 = e_c_reg;  v1 = e_ac_reg; v2 = e_o_reg;  end
                    3'd2:    begin v0 = e_c_reg;  v1 = e_o_reg;  v2 = e_cb_reg; end
                    3'd3:    begin v0 = e_cb_reg; v1 = e_o_reg;  v2 = e_b_reg;  end
                    3'd4:    begin v0 = e_o_reg;  v1 = e_ab_reg; v2 = e_b_reg;  end
                    default: begin v0 = e_o_reg;  v1 = e_a_reg;  v2 = e_ab_reg; end
                endcase
            end
        endcase
    end

    assign piece_valid  = emit_valid_reg;
    assign piece_number = piece_reg;
    assign last_piece   = emit_last;

    assign v0_x = v0[0];
    assign v0_y = v0[1];
    assign v0_z = v0[2];
    assign v1_x = v1[0];
    assign v1_y = v1[1];
    assign v1_z = v1[2];
    assign v2_x = v2[0];
    assign v2_y = v2[1];
    assign v2_z = v2[2];

endmodule

// ===== src/tsub_checker.sv =====
// ----------------------------------------------------------------------------
// tsub_checker: port-level checks of the triangle subdivider
// piece numbering and run framing as seen on the output beats
// ----------------------------------------------------------------------------
module tsub_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       piece_valid,
    input logic [2:0] piece_number,
    input logic       last_piece
);

    // a run has no gaps
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !last_piece |=> piece_valid)
        else $error("gap inside a run of pieces");

    // pieces in a run count up by one
    a_run_counts: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !last_piece |=> piece_number == $past(piece_number) + 3'd1)
        else $error("piece number did not step by one");

    // a beat right after a last piece opens a new run
    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && last_piece ##1 piece_valid |-> piece_number == 3'd0)
        else $error("new run does not start at piece zero");

    // every run holds two, three or six pieces
    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && last_piece |->
            piece_number == 3'd1 || piece_number == 3'd2 || piece_number == 3'd5)
        else $error("run ended at an unexpected piece");

endmodule

bind triangle_subdivider tsub_checker u_tsub_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .piece_valid  (piece_valid),
    .piece_number (piece_number),
    .last_piece   (last_piece)
);
